/* design/rsla_pkg.sv */
// Shared constants and types for the register slave with light average.
`timescale 1ns / 1ps

package rsla_pkg;

	// Register table and protocol sizes.
	localparam int NUM_REGS   = 2;
	localparam int MAX_READ   = 30;
	localparam int REG_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int CNT_W      = 5;
	localparam int FRAME_HELD = 5;
	localparam int FILTER_REG = 1;

	// Function codes carried in the second frame byte.
	localparam logic [7:0] FUNC_WRITE = 8'd6;
	localparam logic [7:0] FUNC_READ  = 8'd3;

	// Command queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Command operation codes.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// One command: for a sample, val holds the reading; for a read, val holds the
	// saturated word count; for a write, val is the value to store.
	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  station;
		logic [15:0] addr;
		logic [15:0] val;
	} cmd_t;

endpackage

/* design/register_slave_with_light_average.sv */
// Top level of the register slave with light-sensor averaging.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_ready    kind, sample, rx_byte
//   out      output     out_valid/out_ready  tx_byte, last
//   cfg      input      cfg_valid/cfg_ready  station_address
//
// The front takes one input transfer per cycle while the four-entry command
// queue has room. The back sequencer dequeues a command, multiplies a
// sensor tick by the reciprocal of ten and updates, stores a write and echoes
// six bytes, or answers a read with three header bytes and two per word,
// one byte per cycle while out_ready is high. Reset clears the register
// table, the frame position and the queue, and sets the station address to
// two. A stalled output holds its byte and backs the queue up to the input.
`timescale 1ns / 1ps

module register_slave_with_light_average (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [9:0] sample,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] station_address
);

	rsla_pkg::cmd_t push_data;
	rsla_pkg::cmd_t pop_data;
	logic           push_valid;
	logic           push_ready;
	logic           pop_valid;
	logic           pop_ready;

	// Frame assembly and classification.
	rsla_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.sample          (sample),
		.rx_byte         (rx_byte),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.station_address (station_address),
		.push_valid      (push_valid),
		.push_ready      (push_ready),
		.push_data       (push_data)
	);

	// Command queue.
	rsla_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Command execution and reply.
	rsla_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.last      (last)
	);

endmodule

/* design/rsla_queue.sv */
// Short command queue that decouples frame decoding from execution.
`timescale 1ns / 1ps

module rsla_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rsla_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rsla_pkg::cmd_t pop_data
);

	rsla_pkg::cmd_t             mem_q [rsla_pkg::QDEPTH];
	logic [rsla_pkg::QAW-1:0]   wr_ptr_q;
	logic [rsla_pkg::QAW-1:0]   rd_ptr_q;
	logic [rsla_pkg::QAW:0]     count_q;
	logic                       do_push;
	logic                       do_pop;

	// Handshake status.
	assign push_ready = (count_q != (rsla_pkg::QAW+1)'(rsla_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage is written on a push transfer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (rsla_pkg::QAW+1)'(rsla_pkg::QDEPTH))
		else $error("queue fill level beyond depth");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue fill level did not drop after a pop");

endmodule

/* design/rsla_front.sv */
// Front part: takes input items, assembles frames and queues commands.
`timescale 1ns / 1ps

module rsla_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           kind,
	input  logic [9:0]     sample,
	input  logic [7:0]     rx_byte,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     station_address,
	output logic           push_valid,
	input  logic           push_ready,
	output rsla_pkg::cmd_t push_data
);

	logic [7:0]             station_q;
	logic [7:0]             fb_q [rsla_pkg::FRAME_HELD];
	logic [2:0]             pos_q;
	logic                   accept;
	logic                   frame_end;
	logic                   is_write;
	logic                   is_read;
	logic [15:0]            val;
	logic [rsla_pkg::CNT_W-1:0] cnt;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ready;
	assign accept    = in_valid && in_ready;
	assign frame_end = (pos_q >= 3'(rsla_pkg::FRAME_HELD));

	// Classify a completed frame against the station address.
	always_comb begin
		val      = {fb_q[4], rx_byte};
		is_write = (fb_q[0] == station_q) && (fb_q[1] == rsla_pkg::FUNC_WRITE);
		is_read  = (fb_q[0] == station_q) && (fb_q[1] == rsla_pkg::FUNC_READ);
		if (val > 16'(rsla_pkg::MAX_READ)) begin
			cnt = rsla_pkg::CNT_W'(rsla_pkg::MAX_READ);
		end else begin
			cnt = val[rsla_pkg::CNT_W-1:0];
		end
	end

	// Build the command for the queue.
	always_comb begin
		push_data.station = fb_q[0];
		push_data.addr    = {fb_q[2], fb_q[3]};
		if (kind == 1'b0) begin
			push_data.op  = rsla_pkg::OP_SAMPLE;
			push_data.val = {6'd0, sample};
			push_valid    = in_valid;
		end else if (is_write) begin
			push_data.op  = rsla_pkg::OP_WRITE;
			push_data.val = val;
			push_valid    = in_valid && frame_end;
		end else begin
			push_data.op  = rsla_pkg::OP_READ;
			push_data.val = {(16 - rsla_pkg::CNT_W)'(0), cnt};
			push_valid    = in_valid && frame_end && is_read;
		end
	end

	// Frame byte store; it needs no reset as a frame is served only once full.
	always_ff @(posedge clk) begin
		if (accept && kind && !frame_end) begin
			fb_q[pos_q] <= rx_byte;
		end
	end

	// Frame position and station address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			station_q <= 8'd2;
		end else begin
			if (cfg_valid && cfg_ready) begin
				station_q <= station_address;
			end
			if (accept && kind) begin
				if (frame_end) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/rsla_back.sv */
// Back part: executes commands, owns the register table and drives replies.
`timescale 1ns / 1ps

module rsla_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  rsla_pkg::cmd_t pop_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     tx_byte,
	output logic           last
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_ECHO = 3'd4;
	localparam logic [2:0] ST_HDR  = 3'd5;
	localparam logic [2:0] ST_DATA = 3'd6;

	// Reciprocal of ten scaled by two to the twentieth, rounded up.
	localparam logic [16:0] DIV10_RECIP = 17'd104858;

	logic [2:0]                 state_q;
	rsla_pkg::cmd_t             cmd_q;
	logic [15:0]                table_q [rsla_pkg::NUM_REGS];
	logic [33:0]                prod_q;
	logic [2:0]                 byte_cnt_q;
	logic [16:0]                rd_idx_q;
	logic [rsla_pkg::CNT_W-1:0] words_q;
	logic                       hi_q;
	logic                       out_valid_q;
	logic [7:0]                 tx_byte_q;
	logic                       last_q;
	logic                       can_emit;
	logic                       emit;
	logic [7:0]                 emit_byte;
	logic                       emit_last;
	logic [16:0]                sum;
	logic [15:0]                word;

	assign out_valid = out_valid_q;
	assign tx_byte   = tx_byte_q;
	assign last      = last_q;
	assign can_emit  = !out_valid_q || out_ready;
	assign pop_ready = (state_q == ST_IDLE);
	assign sum       = {1'b0, table_q[rsla_pkg::FILTER_REG]} + {1'b0, cmd_q.val};

	// Register read for the reply; indexes past the table read as zero.
	always_comb begin
		if (rd_idx_q < 17'(rsla_pkg::NUM_REGS)) begin
			word = table_q[rd_idx_q[rsla_pkg::REG_AW-1:0]];
		end else begin
			word = '0;
		end
	end

	// Select the next reply byte.
	always_comb begin
		emit      = 1'b0;
		emit_byte = '0;
		emit_last = 1'b0;
		case (state_q)
			ST_ECHO: begin
				emit      = can_emit;
				emit_last = (byte_cnt_q == 3'd5);
				case (byte_cnt_q)
					3'd0:    emit_byte = cmd_q.station;
					3'd1:    emit_byte = rsla_pkg::FUNC_WRITE;
					3'd2:    emit_byte = cmd_q.addr[15:8];
					3'd3:    emit_byte = cmd_q.addr[7:0];
					3'd4:    emit_byte = cmd_q.val[15:8];
					default: emit_byte = cmd_q.val[7:0];
				endcase
			end
			ST_HDR: begin
				emit = can_emit;
				case (byte_cnt_q)
					3'd0:    emit_byte = cmd_q.station;
					3'd1:    emit_byte = rsla_pkg::FUNC_READ;
					default: begin
						emit_byte = {(7 - rsla_pkg::CNT_W)'(0), words_q, 1'b0};
						emit_last = (words_q == '0);
					end
				endcase
			end
			ST_DATA: begin
				emit      = can_emit;
				emit_byte = hi_q ? word[15:8] : word[7:0];
				emit_last = !hi_q && (words_q == rsla_pkg::CNT_W'(1));
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Output register: holds a byte until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tx_byte_q <= emit_byte;
			last_q    <= emit_last;
		end
	end

	// Command sequencer and register table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < rsla_pkg::NUM_REGS; i++) begin
				table_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						case (pop_data.op)
							rsla_pkg::OP_SAMPLE: state_q <= ST_MUL;
							rsla_pkg::OP_WRITE:  state_q <= ST_WR;
							rsla_pkg::OP_READ:   state_q <= ST_HDR;
							default:             state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					table_q[rsla_pkg::FILTER_REG] <= {2'b00, prod_q[33:20]};
					state_q <= ST_IDLE;
				end
				ST_WR: begin
					if (cmd_q.addr < 16'(rsla_pkg::NUM_REGS)) begin
						table_q[cmd_q.addr[rsla_pkg::REG_AW-1:0]] <= cmd_q.val;
					end
					state_q <= ST_ECHO;
				end
				ST_ECHO: begin
					if (emit && emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_HDR: begin
					if (emit && (byte_cnt_q == 3'd2)) begin
						state_q <= emit_last ? ST_IDLE : ST_DATA;
					end
				end
				ST_DATA: begin
					if (emit && emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the current command.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pop_valid) begin
			cmd_q      <= pop_data;
			byte_cnt_q <= '0;
			rd_idx_q   <= {1'b0, pop_data.addr};
			words_q    <= pop_data.val[rsla_pkg::CNT_W-1:0];
			hi_q       <= 1'b1;
		end else begin
			if (state_q == ST_MUL) begin
				prod_q <= sum * DIV10_RECIP;
			end
			if (emit && (state_q == ST_ECHO || state_q == ST_HDR)) begin
				byte_cnt_q <= byte_cnt_q + 1'b1;
			end
			if (emit && state_q == ST_DATA) begin
				hi_q <= !hi_q;
				if (!hi_q) begin
					rd_idx_q <= rd_idx_q + 1'b1;
					words_q  <= words_q - 1'b1;
				end
			end
		end
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after the final reply byte");

	a_mul_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_UPD))
		else $error("filter update did not follow the product");

	a_data_words: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DATA) |-> (words_q != '0))
		else $error("register data phase with no words left");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the register slave with light-sensor averaging.
`timescale 1ns / 1ps

module tb;

	localparam int         CLK_PERIOD    = 10;
	localparam logic       KIND_SAMPLE   = 1'b0;
	localparam logic       KIND_BYTE     = 1'b1;
	localparam int         FILTER_DIV    = 10;
	localparam logic [7:0] RESET_STATION = 8'd2;
	localparam int         SETTLE_CYCLES = 64;
	localparam int         LONG_HOLD     = 400;
	localparam int         CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [7:0] tx;
		logic       last;
	} reply_t;

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       in_valid        = 1'b0;
	logic       in_ready;
	logic       kind            = KIND_SAMPLE;
	logic [9:0] sample          = '0;
	logic [7:0] rx_byte         = '0;
	logic       out_valid;
	logic       out_ready       = 1'b0;
	logic [7:0] tx_byte;
	logic       last;
	logic       cfg_valid       = 1'b0;
	logic       cfg_ready;
	logic [7:0] station_address = RESET_STATION;

	// Mirror of the block state used to predict reply bytes.
	logic [15:0] reg_model [rsla_pkg::NUM_REGS];
	logic [7:0]  frame_mem [rsla_pkg::FRAME_HELD];
	int          frame_pos   = 0;
	logic [7:0]  station_now = RESET_STATION;
	reply_t      replies_due [$];
	reply_t      due_reply;

	bit idling        = 1'b1;
	bit tick_mix      = 1'b0;
	bit long_hold_req = 1'b0;
	int stall_left    = 0;
	int items_sent    = 0;
	int errors        = 0;
	int cycle_count   = 0;

	register_slave_with_light_average dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.sample          (sample),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_byte         (tx_byte),
		.last            (last),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.station_address (station_address)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Abandon the run if it has not finished well within the worst case.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	function automatic void push_reply(input logic [7:0] tx, input logic is_last);
		reply_t r;
		r.tx = tx;
		r.last = is_last;
		replies_due.push_back(r);
	endfunction

	// Updates the mirrored state for one accepted input transfer and queues the
	// reply bytes that it causes.
	function automatic void predict_item(input logic k, input logic [9:0] s,
			input logic [7:0] b);
		logic [16:0] sum;
		int unsigned reg_addr;
		int unsigned value;
		int unsigned words;
		int unsigned idx;
		logic [7:0]  count_byte;
		logic [15:0] word;
		if (k == KIND_SAMPLE) begin
			sum = {1'b0, reg_model[rsla_pkg::FILTER_REG]} + {7'd0, s};
			reg_model[rsla_pkg::FILTER_REG] = 16'(sum / FILTER_DIV);
		end else if (frame_pos < rsla_pkg::FRAME_HELD) begin
			frame_mem[frame_pos] = b;
			frame_pos++;
		end else begin
			frame_pos = 0;
			reg_addr = 32'({frame_mem[2], frame_mem[3]});
			value = 32'({frame_mem[4], b});
			if (frame_mem[0] == station_now && frame_mem[1] == rsla_pkg::FUNC_WRITE) begin
				// A write past the table is dropped, but the echo still goes out.
				if (reg_addr < rsla_pkg::NUM_REGS)
					reg_model[reg_addr] = value[15:0];
				for (idx = 0; idx < rsla_pkg::FRAME_HELD; idx++)
					push_reply(frame_mem[idx], 1'b0);
				push_reply(b, 1'b1);
			end else if (frame_mem[0] == station_now &&
					frame_mem[1] == rsla_pkg::FUNC_READ) begin
				// The register index runs on without wrapping, so words past the
				// table read as zero.
				words = (value > rsla_pkg::MAX_READ) ? rsla_pkg::MAX_READ : value;
				count_byte = 8'(words * 2);
				push_reply(frame_mem[0], 1'b0);
				push_reply(frame_mem[1], 1'b0);
				push_reply(count_byte, words == 0);
				for (idx = 0; idx < words; idx++) begin
					word = (reg_addr + idx < rsla_pkg::NUM_REGS) ?
						reg_model[reg_addr + idx] : 16'h0000;
					push_reply(word[15:8], 1'b0);
					push_reply(word[7:0], idx + 1 == words);
				end
			end
		end
	endfunction

	// Receiver: random stalls, plus one long hold-off when asked for.
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = LONG_HOLD;
		end else if (stall_left == 0 && idling && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 9);
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compares each reply transfer with the oldest outstanding prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected reply, expected none, got tx_byte %02h last %0b",
					$time, tx_byte, last);
			end else begin
				due_reply = replies_due.pop_front();
				if (tx_byte !== due_reply.tx) begin
					errors++;
					$display("%0t: tx_byte mismatch, expected %02h, got %02h",
						$time, due_reply.tx, tx_byte);
				end
				if (last !== due_reply.last) begin
					errors++;
					$display("%0t: last mismatch, expected %0b, got %0b",
						$time, due_reply.last, last);
				end
			end
		end
	end

	// Offers one input transfer and waits for it to be taken; the valid stays
	// high unless a random gap follows.
	task automatic send_item(input logic k, input logic [9:0] s, input logic [7:0] b);
		in_valid <= 1'b1;
		kind <= k;
		sample <= s;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		predict_item(k, s, b);
		items_sent++;
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic send_sample(input logic [9:0] s);
		send_item(KIND_SAMPLE, s, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(KIND_BYTE, 10'($urandom_range(0, 1023)), b);
	endtask

	task automatic send_frame(input logic [7:0] addr_byte, input logic [7:0] func,
			input logic [15:0] reg_addr, input logic [15:0] value);
		logic [7:0] frame [6];
		frame = '{addr_byte, func, reg_addr[15:8], reg_addr[7:0], value[15:8], value[7:0]};
		foreach (frame[i]) begin
			if (tick_mix && $urandom_range(0, 19) == 0)
				send_sample(10'($urandom_range(0, 1023)));
			send_byte(frame[i]);
		end
	endtask

	task automatic release_input();
		in_valid <= 1'b0;
	endtask

	// Waits for every predicted reply, then lets any frame that causes no reply
	// work its way through.
	task automatic drain_replies();
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_station(input logic [7:0] value);
		cfg_valid <= 1'b1;
		station_address <= value;
		do @(posedge clk); while (!cfg_ready);
		station_now = value;
		cfg_valid <= 1'b0;
	endtask

	// One random unit: a sensor tick, noise bytes padded back to a frame
	// boundary, or a frame that is mostly well formed.
	task automatic send_random_unit();
		int pick;
		logic [7:0]  addr_byte;
		logic [7:0]  func;
		logic [15:0] reg_addr;
		logic [15:0] value;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_sample(10'($urandom_range(0, 1023)));
		end else if (pick < 16) begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			while (frame_pos != 0) send_byte(8'($urandom_range(0, 255)));
		end else begin
			addr_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
				station_now;
			pick = $urandom_range(0, 9);
			func = (pick < 5) ? rsla_pkg::FUNC_READ :
				(pick < 9) ? rsla_pkg::FUNC_WRITE : 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 9);
			reg_addr = (pick < 7) ? 16'($urandom_range(0, rsla_pkg::NUM_REGS)) :
				(pick < 9) ? 16'hFFFF - 16'($urandom_range(0, 1)) :
				16'($urandom_range(0, 65535));
			pick = $urandom_range(0, 9);
			if (func == rsla_pkg::FUNC_READ)
				value = (pick < 6) ? 16'($urandom_range(0, 4)) :
					(pick < 8) ? 16'($urandom_range(rsla_pkg::MAX_READ - 2,
						rsla_pkg::MAX_READ + 1)) :
					16'($urandom_range(0, 65535));
			else
				value = 16'($urandom_range(0, 65535));
			send_frame(addr_byte, func, reg_addr, value);
		end
	endtask

	task automatic run_random_phase(input int n_items);
		int target;
		target = items_sent + n_items;
		while (items_sent < target) send_random_unit();
		release_input();
		drain_replies();
	endtask

	// Two full-scale readings through the filter.
	task automatic test_sample_filter();
		send_sample(10'd1023);
		send_sample(10'd1023);
	endtask

	task automatic test_write_echo();
		send_frame(station_now, rsla_pkg::FUNC_WRITE, 16'h0000, 16'hFFFF);
	endtask

	// A count far over the limit saturates and runs past the table.
	task automatic test_read_saturated();
		send_frame(station_now, rsla_pkg::FUNC_READ, 16'h0000, 16'hFFFF);
	endtask

	task automatic test_zero_count();
		send_frame(station_now, rsla_pkg::FUNC_READ, 16'h0001, 16'h0000);
	endtask

	task automatic test_dropped_frame();
		send_frame(station_now ^ 8'h80, rsla_pkg::FUNC_WRITE, 16'h0001, 16'h1234);
	endtask

	// The receiver holds off while full-length reads keep arriving: one read is
	// held by the sequencer, four fill the command queue and the last one stalls
	// the input.
	task automatic test_backpressure();
		idling = 1'b0;
		long_hold_req = 1'b1;
		repeat (6) send_frame(station_now, rsla_pkg::FUNC_READ, 16'h0000,
			16'(rsla_pkg::MAX_READ));
		release_input();
		idling = 1'b1;
		drain_replies();
	endtask

	// Random traffic under several station addresses, the extremes among them.
	task automatic test_random_settings();
		logic [7:0] settings [4];
		settings[0] = 8'h00;
		settings[1] = 8'hFF;
		settings[2] = 8'($urandom_range(1, 254));
		settings[3] = RESET_STATION;
		tick_mix = 1'b1;
		foreach (settings[i]) begin
			write_station(settings[i]);
			run_random_phase(30);
		end
	endtask

	task automatic test_quiet_tail();
		idling = 1'b0;
		run_random_phase(40);
	endtask

	initial begin
		foreach (reg_model[i]) reg_model[i] = '0;
		foreach (frame_mem[i]) frame_mem[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_sample_filter();
		test_write_echo();
		test_read_saturated();
		test_zero_count();
		test_dropped_frame();
		release_input();
		drain_replies();
		test_backpressure();
		test_random_settings();
		test_quiet_tail();
		if (errors == 0 && replies_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

/* register_slave_with_light_average.f */
design/rsla_pkg.sv
design/rsla_queue.sv
design/rsla_front.sv
design/rsla_back.sv
design/register_slave_with_light_average.sv
dv/tb.sv
